/* rtl/ssm_pkg.sv */
// Package for the sorted sequence merge block.
// Holds the data width, the default store depth and the command codes.
// No dependencies.
package ssm_pkg;

    localparam int DATA_W        = 32;
    localparam int DEPTH_DEFAULT = 32;
    localparam int FUNC_W        = 2;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_APPEND_FIRST  = 2'd0,
        FUNC_APPEND_SECOND = 2'd1,
        FUNC_MERGE         = 2'd2
    } func_t;

endpackage

/* rtl/ssm_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module ssm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32,
    parameter int AW    = 5
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/ssm_seq.sv */
// Command decoder and merge sequencer with the shared head comparator.
// Uses ssm_pkg; drives the write and read ports of the two element RAMs.
module ssm_seq
    import ssm_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT,
    parameter int AW    = 5,
    parameter int CW    = 6
) (
    input  logic              clk,
    input  logic              rst_n,
    // request side
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [FUNC_W-1:0] in_func,
    // RAM ports
    output logic              first_we,
    output logic              second_we,
    output logic [AW-1:0]     first_waddr,
    output logic [AW-1:0]     second_waddr,
    output logic [AW-1:0]     first_raddr,
    output logic [AW-1:0]     second_raddr,
    input  logic [DATA_W-1:0] first_rdata,
    input  logic [DATA_W-1:0] second_rdata,
    // result side
    output logic              out_valid,
    input  logic              out_ready,
    output logic [DATA_W-1:0] out_value,
    output logic              out_second,
    output logic              out_last,
    output logic              out_dropped
);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_FETCH = 4'b0010,
        ST_PICK  = 4'b0100,
        ST_SEND  = 4'b1000
    } state_t;

    state_t            state_reg, state_next;
    logic [CW-1:0]     first_cnt_reg, first_cnt_next;
    logic [CW-1:0]     second_cnt_reg, second_cnt_next;
    logic [CW-1:0]     first_idx_reg, first_idx_next;
    logic [CW-1:0]     second_idx_reg, second_idx_next;
    logic              ovf_reg, ovf_next;
    logic [DATA_W-1:0] value_reg;
    logic              second_reg;
    logic              last_reg;

    logic          accept;
    logic          first_full, second_full;
    logic          have_first, have_second, take_first;
    logic [CW-1:0] first_idx_inc, second_idx_inc;

    assign accept      = in_valid && in_ready;
    assign in_ready    = (state_reg == ST_IDLE);
    assign first_full  = (first_cnt_reg == CW'(DEPTH));
    assign second_full = (second_cnt_reg == CW'(DEPTH));

    assign first_we     = accept && (in_func == FUNC_APPEND_FIRST) && !first_full;
    assign second_we    = accept && (in_func == FUNC_APPEND_SECOND) && !second_full;
    assign first_waddr  = first_cnt_reg[AW-1:0];
    assign second_waddr = second_cnt_reg[AW-1:0];
    assign first_raddr  = first_idx_reg[AW-1:0];
    assign second_raddr = second_idx_reg[AW-1:0];

    assign first_idx_inc  = first_idx_reg + CW'(1);
    assign second_idx_inc = second_idx_reg + CW'(1);

    // On a tie the second sequence goes first.
    assign have_first  = (first_idx_reg < first_cnt_reg);
    assign have_second = (second_idx_reg < second_cnt_reg);
    always_comb
    begin
        if (have_first && have_second)
        begin
            take_first = $signed(first_rdata) < $signed(second_rdata);
        end
        else
        begin
            take_first = have_first;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        first_cnt_next  = first_cnt_reg;
        second_cnt_next = second_cnt_reg;
        first_idx_next  = first_idx_reg;
        second_idx_next = second_idx_reg;
        ovf_next        = ovf_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (in_func)
                        FUNC_APPEND_FIRST:
                        begin
                            if (first_full)
                            begin
                                ovf_next = 1'b1;
                            end
                            else
                            begin
                                first_cnt_next = first_cnt_reg + CW'(1);
                            end
                        end
                        FUNC_APPEND_SECOND:
                        begin
                            if (second_full)
                            begin
                                ovf_next = 1'b1;
                            end
                            else
                            begin
                                second_cnt_next = second_cnt_reg + CW'(1);
                            end
                        end
                        FUNC_MERGE:
                        begin
                            first_idx_next  = '0;
                            second_idx_next = '0;
                            if (first_cnt_reg == '0 && second_cnt_reg == '0)
                            begin
                                ovf_next = 1'b0;
                            end
                            else
                            begin
                                state_next = ST_FETCH;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_FETCH:
            begin
                state_next = ST_PICK;
            end
            ST_PICK:
            begin
                if (take_first)
                begin
                    first_idx_next = first_idx_inc;
                end
                else
                begin
                    second_idx_next = second_idx_inc;
                end
                state_next = ST_SEND;
            end
            ST_SEND:
            begin
                if (out_ready)
                begin
                    if (last_reg)
                    begin
                        first_cnt_next  = '0;
                        second_cnt_next = '0;
                        ovf_next        = 1'b0;
                        state_next      = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_FETCH;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            first_cnt_reg  <= '0;
            second_cnt_reg <= '0;
            first_idx_reg  <= '0;
            second_idx_reg <= '0;
            ovf_reg        <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            first_cnt_reg  <= first_cnt_next;
            second_cnt_reg <= second_cnt_next;
            first_idx_reg  <= first_idx_next;
            second_idx_reg <= second_idx_next;
            ovf_reg        <= ovf_next;
        end
    end

    // The run ends when the pick exhausts both sequences.
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_PICK)
        begin
            value_reg  <= take_first ? first_rdata : second_rdata;
            second_reg <= !take_first;
            if (take_first)
            begin
                last_reg <= (first_idx_inc == first_cnt_reg)
                            && (second_idx_reg == second_cnt_reg);
            end
            else
            begin
                last_reg <= (first_idx_reg == first_cnt_reg)
                            && (second_idx_inc == second_cnt_reg);
            end
        end
    end

    assign out_valid   = (state_reg == ST_SEND);
    assign out_value   = value_reg;
    assign out_second  = second_reg;
    assign out_last    = last_reg;
    assign out_dropped = ovf_reg;

endmodule

/* rtl/sorted_sequence_merge.sv */
// Top level of the sorted sequence merge block.
// Uses ssm_pkg, ssm_ram (two element stores) and ssm_seq (sequencer).
//
// Usage:
// A request on the s_ channel carries a command in s_tuser and a value in
// s_tdata. Commands append to the first or second sequence (no result) or
// merge. A merge emits every stored element on the m_ channel, taking the
// smaller signed head each time (ascending order for sorted sequences); on
// equal heads the second sequence goes first. The final element of the run
// carries m_tlast, and m_tuser[1] reports whether an append was dropped on
// a full sequence since the previous merge. For each element in turn a merge
// reads the RAMs, compares the heads in the shared comparator and then
// outputs the chosen element; a merge of two empty sequences gives no result.
// s_tready is low for the whole merge.
// When the receiver stalls, the current result holds in the output
// register and the sequencer waits. Reset empties both sequences and clears
// the drop flag; the stores themselves are not cleared.
module sorted_sequence_merge
    import ssm_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [DATA_W-1:0] s_tdata,   // [31:0] value
    input  logic [FUNC_W-1:0] s_tuser,   // [1:0] func
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [DATA_W-1:0] m_tdata,   // [31:0] merged_value
    output logic              m_tlast,
    output logic [1:0]        m_tuser    // [0] from_second, [1] dropped
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic              first_we, second_we;
    logic [AW-1:0]     first_waddr, second_waddr;
    logic [AW-1:0]     first_raddr, second_raddr;
    logic [DATA_W-1:0] first_rdata, second_rdata;
    logic              out_second, out_dropped;

    ssm_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_first_ram (
        .clk   (clk),
        .we    (first_we),
        .waddr (first_waddr),
        .wdata (s_tdata),
        .raddr (first_raddr),
        .rdata (first_rdata)
    );

    ssm_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_second_ram (
        .clk   (clk),
        .we    (second_we),
        .waddr (second_waddr),
        .wdata (s_tdata),
        .raddr (second_raddr),
        .rdata (second_rdata)
    );

    ssm_seq #(
        .DEPTH (DEPTH),
        .AW    (AW),
        .CW    (CW)
    ) u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (s_tvalid),
        .in_ready     (s_tready),
        .in_func      (s_tuser),
        .first_we     (first_we),
        .second_we    (second_we),
        .first_waddr  (first_waddr),
        .second_waddr (second_waddr),
        .first_raddr  (first_raddr),
        .second_raddr (second_raddr),
        .first_rdata  (first_rdata),
        .second_rdata (second_rdata),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .out_value    (m_tdata),
        .out_second   (out_second),
        .out_last     (m_tlast),
        .out_dropped  (out_dropped)
    );

    assign m_tuser = {out_dropped, out_second};

endmodule

/* dv/tb.sv */
// Self-checking testbench for the sorted sequence merge block.
// Uses ssm_pkg and the sorted_sequence_merge top level; a small scoreboard
// class predicts every merged run and checks the output stream against it.
`timescale 1ns / 100ps

module tb;
    import ssm_pkg::*;

    localparam int          SEQ_DEPTH    = DEPTH_DEFAULT;
    localparam int          RANDOM_ITEMS = 230;
    localparam int          CALM_ITEMS   = 190;
    localparam int          CYCLE_LIMIT  = 200000;
    localparam logic [1:0]  FUNC_UNUSED  = 2'd3;

    typedef struct packed {
        logic [DATA_W-1:0] value;
        logic              from_second;
        logic              last;
        logic              dropped;
    } merged_item_t;

    // Keeps its own copy of both sequences and the drop flag, and the
    // merged elements that are still to come out of the block.
    class merge_scoreboard;
        int           first_seq[$];
        int           second_seq[$];
        bit           overflow_seen;
        merged_item_t merged_q[$];
        int           errors;

        function void note_request(logic [1:0] func, logic [DATA_W-1:0] value);
            int           total;
            bit           take_first;
            merged_item_t item;
            if (func == FUNC_APPEND_FIRST)
            begin
                if (first_seq.size() < SEQ_DEPTH)
                    first_seq.push_back(value);
                else
                    overflow_seen = 1'b1;
            end
            else if (func == FUNC_APPEND_SECOND)
            begin
                if (second_seq.size() < SEQ_DEPTH)
                    second_seq.push_back(value);
                else
                    overflow_seen = 1'b1;
            end
            else if (func == FUNC_MERGE)
            begin
                total = first_seq.size() + second_seq.size();
                for (int k = 0; k < total; k++)
                begin
                    // The first head wins only when strictly smaller.
                    if (first_seq.size() > 0 && second_seq.size() > 0)
                        take_first = first_seq[0] < second_seq[0];
                    else
                        take_first = first_seq.size() > 0;
                    if (take_first)
                    begin
                        item.value       = first_seq.pop_front();
                        item.from_second = 1'b0;
                    end
                    else
                    begin
                        item.value       = second_seq.pop_front();
                        item.from_second = 1'b1;
                    end
                    item.last    = (k == total - 1);
                    item.dropped = overflow_seen;
                    merged_q.push_back(item);
                end
                overflow_seen = 1'b0;
            end
        endfunction

        function void check_result(logic [DATA_W-1:0] data, logic last, logic [1:0] user);
            merged_item_t got;
            merged_item_t want;
            got.value       = data;
            got.from_second = user[0];
            got.last        = last;
            got.dropped     = user[1];
            if (merged_q.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result: value %0d second %0b last %0b dropped %0b",
                         $time, $signed(got.value), got.from_second, got.last, got.dropped);
            end
            else
            begin
                want = merged_q.pop_front();
                if (got !== want)
                begin
                    errors++;
                    $display("%0t: mismatch: expected %0d/%0b/%0b/%0b, actual %0d/%0b/%0b/%0b",
                             $time, $signed(want.value), want.from_second, want.last,
                             want.dropped, $signed(got.value), got.from_second, got.last,
                             got.dropped);
                end
            end
        endfunction
    endclass

    logic              clk;
    logic              rst_n;
    logic              s_tvalid;
    logic              s_tready;
    logic [DATA_W-1:0] s_tdata;
    logic [FUNC_W-1:0] s_tuser;
    logic              m_tvalid;
    logic              m_tready;
    logic [DATA_W-1:0] m_tdata;
    logic              m_tlast;
    logic [1:0]        m_tuser;

    merge_scoreboard sb = new();
    int              items_sent;
    int              cycle_count;
    bit              gaps_on;
    bit              drained_once;

    sorted_sequence_merge #(
        .DEPTH(SEQ_DEPTH)
    ) DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tlast (m_tlast),
        .m_tuser (m_tuser)
    );

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_result(m_tdata, m_tlast, m_tuser);
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Receiver side: random stall bursts while gaps are enabled.
    initial
    begin
        m_tready = 1'b0;
        wait (rst_n);
        forever
        begin
            if (gaps_on && $urandom_range(0, 2) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge clk);
            end
            m_tready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
    end

    // Holds one request on the slave side until it is taken.
    task automatic send_request(input logic [1:0] func, input logic [DATA_W-1:0] value);
        if (gaps_on && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        s_tuser  <= func;
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_request(func, value);
        if (func != FUNC_UNUSED)
            items_sent++;
    endtask

    // The sender goes idle so that no request is taken a second time.
    task automatic wait_for_drain();
        s_tvalid <= 1'b0;
        while (sb.merged_q.size() != 0)
            @(posedge clk);
    endtask

    // Builds two sequences, feeds their appends in a random interleave and
    // then merges. Ties are made by copying values across the sequences.
    task automatic send_batch(input int n1, input int n2, input bit ordered);
        int first_vals[$];
        int second_vals[$];
        for (int i = 0; i < n1; i++)
            first_vals.push_back($urandom);
        for (int i = 0; i < n2; i++)
        begin
            if (n1 > 0 && $urandom_range(0, 3) == 0)
                second_vals.push_back(first_vals[$urandom_range(0, n1 - 1)]);
            else
                second_vals.push_back($urandom);
        end
        if (ordered)
        begin
            first_vals.sort();
            second_vals.sort();
        end
        while (first_vals.size() > 0 || second_vals.size() > 0)
        begin
            if (first_vals.size() > 0 && (second_vals.size() == 0 || $urandom_range(0, 1)))
                send_request(FUNC_APPEND_FIRST, first_vals.pop_front());
            else
                send_request(FUNC_APPEND_SECOND, second_vals.pop_front());
            if ($urandom_range(0, 15) == 0)
                send_request(FUNC_UNUSED, $urandom);
        end
        send_request(FUNC_MERGE, $urandom);
    endtask

    initial
    begin
        clk          = 1'b0;
        rst_n        = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = '0;
        gaps_on      = 1'b1;
        drained_once = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Extremes on both sides, with ties at both ends of the range.
        send_request(FUNC_APPEND_FIRST, 32'h8000_0000);
        send_request(FUNC_APPEND_FIRST, 32'h7FFF_FFFF);
        send_request(FUNC_APPEND_SECOND, 32'h8000_0000);
        send_request(FUNC_APPEND_SECOND, 32'h0000_0000);
        send_request(FUNC_APPEND_SECOND, 32'h7FFF_FFFF);
        send_request(FUNC_MERGE, 32'hFFFF_FFFF);
        // Both sequences empty.
        send_request(FUNC_MERGE, 32'h0000_0000);
        // Second sequence empty, with an unused code in between.
        send_request(FUNC_APPEND_FIRST, 32'hFFFF_FFFF);
        send_request(FUNC_UNUSED, 32'h1234_5678);
        send_request(FUNC_APPEND_FIRST, 32'h0000_0001);
        send_request(FUNC_MERGE, 32'h5555_5555);
        // First sequence empty.
        send_request(FUNC_APPEND_SECOND, 32'hFFFF_FFFD);
        send_request(FUNC_APPEND_SECOND, 32'hAAAA_AAAA);
        send_request(FUNC_MERGE, 32'hAAAA_AAAA);
        // Unsorted sequences still go through the same head comparison.
        send_request(FUNC_APPEND_FIRST, 32'd10);
        send_request(FUNC_APPEND_FIRST, 32'd2);
        send_request(FUNC_APPEND_SECOND, 32'd5);
        send_request(FUNC_APPEND_SECOND, 32'd1);
        send_request(FUNC_MERGE, 32'd0);

        // One full first sequence with appends past the end to set the drop flag.
        items_sent = 0;
        send_batch(SEQ_DEPTH + 1, $urandom_range(0, SEQ_DEPTH + 1), 1'b1);
        while (items_sent < RANDOM_ITEMS)
        begin
            if (items_sent >= CALM_ITEMS)
                gaps_on = 1'b0;
            if ($urandom_range(0, 9) == 0)
                send_batch($urandom_range(0, 6), $urandom_range(0, 6), 1'b0);
            else if ($urandom_range(0, 19) == 0)
                send_batch($urandom_range(0, SEQ_DEPTH), $urandom_range(0, SEQ_DEPTH), 1'b1);
            else
                send_batch($urandom_range(0, 6), $urandom_range(0, 6), 1'b1);
            if (!drained_once && items_sent >= RANDOM_ITEMS / 2)
            begin
                wait_for_drain();
                drained_once = 1'b1;
            end
        end
        s_tvalid <= 1'b0;

        wait_for_drain();
        repeat (20) @(posedge clk);
        if (sb.errors == 0 && sb.merged_q.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
